### rtl/core/assert_macros.svh
// Assertion macros used by the checker file, ssmd_checker.sv.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ssmd_pkg.sv
// Shared constants, types and helpers for the subarray sum multiple detector.
// No dependencies; used by the interfaces, the modulo unit and the top level.
package ssmd_pkg;

	localparam int MAX_MODULUS = 1024;
	localparam int MAX_LENGTH  = 65536;

	localparam int VALUE_W = 30;
	localparam int MOD_W   = 11;
	localparam int RES_W   = $clog2(MAX_MODULUS);
	localparam int POS_W   = $clog2(MAX_LENGTH) + 1;
	localparam int SUM_W   = VALUE_W + 1;
	localparam int CNT_W   = $clog2(SUM_W + 1);
	localparam int EPOCH_W = 8;

	localparam logic [MOD_W-1:0] K_MAX = MOD_W'(MAX_MODULUS);
	localparam logic [POS_W-1:0] LEN_MAX = POS_W'(MAX_LENGTH);

	// one entry of the first-seen memory: sequence tag and first position
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [POS_W-1:0]   pos;
	} entry_t;

	// modulo unit status toward the controller
	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] rem;
	} mod_res_t;

	// zero acts as 1, anything above the table size is clamped
	function automatic logic [MOD_W-1:0] eff_modulus(input logic [MOD_W-1:0] k);
		logic [MOD_W-1:0] r;
		if (k == '0) begin
			r = MOD_W'(1);
		end else if (k > K_MAX) begin
			r = K_MAX;
		end else begin
			r = k;
		end
		return r;
	endfunction

endpackage

### rtl/core/ssmd_ifs.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on ssmd_pkg for the field widths.
interface ssmd_in_if;
	logic                          valid;
	logic                          ready;
	logic [ssmd_pkg::VALUE_W-1:0]  value;
	logic                          last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface ssmd_out_if;
	logic valid;
	logic ready;
	logic found;
	logic overflow;

	modport source (output valid, output found, output overflow, input ready);
	modport sink   (input valid, input found, input overflow, output ready);
endinterface

### rtl/core/subarray_sum_multiple_detect.sv
// Flow: one item at a time: accept, bit-serial modulo (one shift per dividend bit, then a done
// strobe), one memory read, one update. Items past the length limit go straight to the update.
// Latency: the result is valid on the cycle after the last item's update; that update waits
// while an earlier result is still held.
// Reset: async, active low. After reset and every 255 sequences a sweep clears the first-seen
// memory (no transactions, config writes allowed). Uses ssmd_pkg, ssmd_mod_unit.
module subarray_sum_multiple_detect (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssmd_pkg::MOD_W-1:0]   cfg_wdata,
	ssmd_in_if.sink                      in_ch,
	ssmd_out_if.source                   out_ch
);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_DIV, ST_RD, ST_UPD} state_t;

	state_t                         state_q;
	logic [ssmd_pkg::RES_W-1:0]     clr_cnt_q;
	logic [ssmd_pkg::EPOCH_W-1:0]   epoch_q;
	logic [ssmd_pkg::MOD_W-1:0]     modulus_q;
	logic [ssmd_pkg::POS_W-1:0]     pos_q;
	logic [ssmd_pkg::RES_W-1:0]     res_q;
	logic                           found_q;
	logic                           ovf_q;
	logic                           last_q;
	logic                           skip_q;
	logic [ssmd_pkg::RES_W-1:0]     r_q;
	ssmd_pkg::entry_t               rdata_q;
	logic                           out_valid_q;
	logic                           out_found_q;
	logic                           out_ovf_q;

	ssmd_pkg::entry_t               mem [ssmd_pkg::MAX_MODULUS];

	ssmd_pkg::mod_res_t             mod_res;
	logic                           in_fire;
	logic                           too_long;
	logic                           mod_start;
	logic [ssmd_pkg::SUM_W-1:0]     dividend;
	logic                           hit;
	logic [ssmd_pkg::POS_W-1:0]     pos_gap;
	logic                           upd_go;
	logic                           mem_we;
	logic                           found_n;
	logic                           ovf_n;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign too_long    = (pos_q >= ssmd_pkg::LEN_MAX);
	assign mod_start   = in_fire && !too_long;
	assign dividend    = {1'b0, in_ch.value} + ssmd_pkg::SUM_W'(res_q);

	ssmd_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (dividend),
		.divisor  (ssmd_pkg::eff_modulus(modulus_q)),
		.res      (mod_res)
	);

	// a final item waits in update while the previous result is still held
	assign upd_go = (state_q == ST_UPD) && (!last_q || !out_valid_q || out_ch.ready);

	always_comb begin
		hit     = (rdata_q.epoch == epoch_q);
		pos_gap = pos_q - rdata_q.pos;
		found_n = found_q;
		ovf_n   = ovf_q;
		mem_we  = 1'b0;
		if (skip_q) begin
			ovf_n = 1'b1;
		end else if (r_q == '0) begin
			if (pos_q != '0) begin
				found_n = 1'b1;
			end
		end else if (hit) begin
			if (pos_gap > ssmd_pkg::POS_W'(1)) begin
				found_n = 1'b1;
			end
		end else begin
			mem_we = upd_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			epoch_q     <= '0;
			modulus_q   <= ssmd_pkg::MOD_W'(1);
			pos_q       <= '0;
			res_q       <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (upd_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						epoch_q <= ssmd_pkg::EPOCH_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= too_long ? ST_UPD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_res.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						if (last_q) begin
							found_q <= 1'b0;
							ovf_q   <= 1'b0;
							pos_q   <= '0;
							res_q   <= '0;
							epoch_q <= epoch_q + 1'b1;
							// tag zero means never written; sweep before reusing tags
							state_q <= (epoch_q == '1) ? ST_CLEAR : ST_IDLE;
						end else begin
							found_q <= found_n;
							ovf_q   <= ovf_n;
							if (!skip_q) begin
								res_q <= r_q;
								pos_q <= pos_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= in_ch.last;
			skip_q <= too_long;
		end
		if (mod_res.done) begin
			r_q <= mod_res.rem;
		end
		if (upd_go && last_q) begin
			out_found_q <= found_n;
			out_ovf_q   <= ovf_n;
		end
	end

	// first-seen memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_cnt_q] <= '0;
		end else if (mem_we) begin
			mem[r_q] <= '{epoch: epoch_q, pos: pos_q};
		end
		if (state_q == ST_RD) begin
			rdata_q <= mem[r_q];
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.found    = out_found_q;
	assign out_ch.overflow = out_ovf_q;

endmodule

### rtl/core/ssmd_mod_unit.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on ssmd_pkg for widths and the status struct.
module ssmd_mod_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssmd_pkg::SUM_W-1:0]   dividend,
	input  logic [ssmd_pkg::MOD_W-1:0]   divisor,
	output ssmd_pkg::mod_res_t           res
);

	logic                         busy_q;
	logic                         done_q;
	logic [ssmd_pkg::CNT_W-1:0]   cnt_q;
	logic [ssmd_pkg::SUM_W-1:0]   dvd_q;
	logic [ssmd_pkg::MOD_W-1:0]   div_q;
	logic [ssmd_pkg::RES_W-1:0]   rem_q;
	logic [ssmd_pkg::MOD_W-1:0]   trial;
	logic [ssmd_pkg::RES_W-1:0]   rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[ssmd_pkg::SUM_W-1]};
		if (trial >= div_q) begin
			rem_next = ssmd_pkg::RES_W'(trial - div_q);
		end else begin
			rem_next = ssmd_pkg::RES_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssmd_pkg::CNT_W'(ssmd_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssmd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ssmd_pkg::SUM_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

### rtl/core/ssmd_checker.sv
// Port-level checks for subarray_sum_multiple_detect, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssmd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic overflow
);

	// a held result keeps its payload until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(overflow), "result changed while stalled")

	// one item at a time: no second transaction right behind an accepted one
	`ASSERT_NEXT(a_in_gap, clk, arst_n, in_valid && in_ready, !in_ready, "input ready right after a transaction")

	// a result does not rise in the cycle right after its input transaction
	`ASSERT_NEXT(a_no_instant, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result rose right after a transaction")

endmodule

bind subarray_sum_multiple_detect ssmd_checker u_ssmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.found     (out_ch.found),
	.overflow  (out_ch.overflow)
);
